### rtl/rbb_pkg.sv
// shared types and constants for the rgba 3x3 box blur
package rbb_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 4 * CH_W;
  localparam int DIM_W  = 11;
  localparam int WIN_N  = 9;
  localparam int SUM_W  = 12;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RST        = 1024;

  // reciprocals for truncated division of sums below 2^15
  localparam int RECIP6_W     = 14;
  localparam int RECIP6       = 10923;
  localparam int RECIP6_SHIFT = 16;
  localparam int RECIP9       = 3641;
  localparam int RECIP9_SHIFT = 15;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // red in the lowest byte
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // which neighbours of the centre pixel lie inside the frame, and the frame end
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } res_flags_t;

endpackage

### rtl/rbb_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module rbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/rbb_mean.sv
// edge-aware mean of the 3x3 window, per colour channel
module rbb_mean (
  input  rbb_pkg::pixel_t     win [rbb_pkg::WIN_N],
  input  rbb_pkg::res_flags_t flags,
  output rbb_pkg::pixel_t     mean_pix,
  output logic                mean_last
);

  import rbb_pkg::*;

  typedef enum logic [1:0] {
    DIV4 = 2'd0,
    DIV6 = 2'd1,
    DIV9 = 2'd2
  } div_sel_t;

  logic [2:0]                      row_ok;
  logic [2:0]                      col_ok;
  div_sel_t                        div_sel;
  logic [SUM_W-1:0]                sum    [3];
  logic [SUM_W+RECIP6_W-1:0]       prod6  [3];
  logic [SUM_W+RECIP6_W-1:0]       prod9  [3];
  logic [CH_W-1:0]                 quot   [3];

  assign row_ok = {flags.bot, 1'b1, flags.top};
  assign col_ok = {flags.right, 1'b1, flags.left};

  // frame is at least 2x2, so each axis spans two or three pixels
  always_comb begin
    if (flags.top && flags.bot && flags.left && flags.right) begin
      div_sel = DIV9;
    end else if ((flags.top && flags.bot) || (flags.left && flags.right)) begin
      div_sel = DIV6;
    end else begin
      div_sel = DIV4;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sum[ch] = sum[ch] + SUM_W'(win[r*3+c][ch*CH_W +: CH_W]);
          end
        end
      end
      prod6[ch] = (SUM_W+RECIP6_W)'(sum[ch]) * (SUM_W+RECIP6_W)'(RECIP6);
      prod9[ch] = (SUM_W+RECIP6_W)'(sum[ch]) * (SUM_W+RECIP6_W)'(RECIP9);
      unique case (div_sel)
        DIV9:    quot[ch] = prod9[ch][RECIP9_SHIFT +: CH_W];
        DIV6:    quot[ch] = prod6[ch][RECIP6_SHIFT +: CH_W];
        default: quot[ch] = sum[ch][2 +: CH_W];
      endcase
    end
  end

  assign mean_pix.red   = quot[0];
  assign mean_pix.green = quot[1];
  assign mean_pix.blue  = quot[2];
  assign mean_pix.alpha = win[4].alpha;
  assign mean_last      = flags.last;

endmodule

### rtl/rgba_box_blur_3x3_edge_mean.sv
// top level of the rgba 3x3 box blur with edge-aware mean
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   in_     | in  | tvalid / tready    | tdata pixel, tuser drain flag
//   out_    | out | tvalid / tready    | tdata blurred pixel, tlast frame end
//   cfg_    | in  | valid / ready      | index, data (width or height)
//
// one beat per clock in both directions unless stalled; a result moves
// through the window register, then the output register, after the beat
// that completes its neighbourhood; the line store read is prefetched
// for the next column; synchronous active-low reset clears counters and
// valid flags and restores the default width and height; in_tready drops
// only while a finished window waits behind a full, stalled output register
module rgba_box_blur_3x3_edge_mean #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input pixel stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rbb_pkg::PIX_W-1:0]     in_tdata,   // red, green, blue, alpha
  input  logic                          in_tuser,   // op: 0 pixel, 1 drain
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rbb_pkg::PIX_W-1:0]     out_tdata,  // red, green, blue, alpha
  output logic                          out_tlast,  // frame_last
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::DIM_W-1:0]     cfg_data
);

  import rbb_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = DIM_W + 1;
  localparam logic [DIM_W-1:0] WD_RST =
    DIM_W'((MAX_WIDTH < DIM_RST) ? MAX_WIDTH : DIM_RST);
  localparam logic [DIM_W-1:0] HT_RST =
    DIM_W'((MAX_HEIGHT < DIM_RST) ? MAX_HEIGHT : DIM_RST);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int maxv);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(2)) begin
      res = DIM_W'(2);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // frame geometry, already clamped
  logic [DIM_W-1:0] wd_r, wd_nxt;
  logic [DIM_W-1:0] ht_r, ht_nxt;

  // input position and result position
  logic [DIM_W-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0]    in_row_r, in_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt;
  logic [DIM_W-1:0] out_row_r, out_row_nxt;

  // window stage and output register
  pixel_t     win_r [WIN_N];
  logic       p1_valid_r, p1_valid_nxt;
  res_flags_t p1_flags_r, p1_flags_nxt;
  pixel_t     out_pix_r;
  logic       out_last_r;
  logic       out_tvalid_r;

  // line store, both rows of one column in one word
  logic [2*PIX_W-1:0] ls_rd;
  logic [2*PIX_W-1:0] ls_wr;
  logic               ls_we;

  logic       in_acc, cfg_acc;
  logic       in_frame, step, produce, col_wrap, out_col_wrap;
  logic       out_free, move;
  pixel_t     pix;
  pixel_t     col_top, col_mid;
  res_flags_t res_flags;
  pixel_t     mean_pix;
  logic       mean_last;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // output side: window moves on when the output register is free
  assign out_free  = !out_tvalid_r || out_tready;
  assign move      = p1_valid_r && out_free;
  assign in_tready = !p1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // a drain inside the frame changes nothing; past the frame any beat drains
  assign in_frame = in_row_r < {1'b0, ht_r};
  assign step     = in_acc && !(in_frame && in_tuser);
  assign pix      = in_frame ? pixel_t'(in_tdata) : pixel_t'('0);
  // the first row and one pixel fill the window before any result
  assign produce  = !((in_row_r == '0) || ((in_row_r == RW'(1)) && (in_col_r == '0)));
  assign col_wrap = in_col_r == wd_r - DIM_W'(1);

  // row parity picks which half is two rows up and which is one row up
  assign col_top = in_row_r[0] ? pixel_t'(ls_rd[PIX_W +: PIX_W]) : pixel_t'(ls_rd[0 +: PIX_W]);
  assign col_mid = in_row_r[0] ? pixel_t'(ls_rd[0 +: PIX_W]) : pixel_t'(ls_rd[PIX_W +: PIX_W]);
  assign ls_we   = step;
  assign ls_wr   = in_row_r[0] ? {pix, ls_rd[0 +: PIX_W]} : {ls_rd[PIX_W +: PIX_W], pix};

  // neighbourhood validity of the next result pixel
  assign out_col_wrap    = out_col_r == wd_r - DIM_W'(1);
  assign res_flags.top   = out_row_r != '0;
  assign res_flags.bot   = out_row_r != ht_r - DIM_W'(1);
  assign res_flags.left  = out_col_r != '0;
  assign res_flags.right = !out_col_wrap;
  assign res_flags.last  = !res_flags.bot && out_col_wrap;

  always_comb begin
    wd_nxt       = wd_r;
    ht_nxt       = ht_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    p1_valid_nxt = p1_valid_r;
    p1_flags_nxt = p1_flags_r;
    if (move) begin
      p1_valid_nxt = 1'b0;
    end
    if (step) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (produce) begin
        p1_valid_nxt = 1'b1;
        p1_flags_nxt = res_flags;
        if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
        // end of frame: start over, window keeps its data for the last result
        if (res_flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
    // any register write restarts the frame
    if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  wd_nxt = clamp_dim(cfg_data, MAX_WIDTH);
        REG_IMAGE_HEIGHT: ht_nxt = clamp_dim(cfg_data, MAX_HEIGHT);
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      p1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r         <= WD_RST;
      ht_r         <= HT_RST;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      p1_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      wd_r       <= wd_nxt;
      ht_r       <= ht_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      p1_valid_r <= p1_valid_nxt;
      if (move) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // window shift and payload registers
  always_ff @(posedge clk) begin
    p1_flags_r <= p1_flags_nxt;
    if (step) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= col_top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= col_mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix;
    end
    if (move) begin
      out_pix_r  <= mean_pix;
      out_last_r <= mean_last;
    end
  end

  // read address follows the column of the next beat
  rbb_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ls_we),
    .wr_addr (AW'(in_col_r)),
    .wr_data (ls_wr),
    .rd_addr (AW'(in_col_nxt)),
    .rd_data (ls_rd)
  );

  rbb_mean u_mean (
    .win       (win_r),
    .flags     (p1_flags_r),
    .mean_pix  (mean_pix),
    .mean_last (mean_last)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule
